>>> hw/rtl/easu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// easu_pkg
// Shared types and constants of the encoder angle and speed update block.
// ----------------------------------------------------------------------------
package easu_pkg;

   localparam int TS_W       = 32;
   localparam int CNT_W      = 32;
   localparam int ANGLE_W    = 34;
   localparam int SPEED_W    = 32;
   localparam int WIN_W      = 31;
   localparam int TPS_W      = 30;
   localparam int NUM_W      = 64;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // two quotient bits per divider cycle
   localparam int DIV_CYCLES = NUM_W / 2;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(21000000);
   localparam logic [TPS_W-1:0] TPS_RESET    = TPS_W'(84000000);

   localparam logic [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
   localparam logic [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

   typedef enum logic {
      REG_WINDOW = 1'b0,
      REG_TPS    = 1'b1
   } reg_sel_type;

   typedef enum logic {
      FUNC_RESTART = 1'b0,
      FUNC_POLL    = 1'b1
   } func_type;

   typedef struct packed {
      logic capture;
      logic multiply;
      logic div_init;
      logic div_step;
      logic saturate;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic update;
      logic slot_free;
   } status_type;

endpackage

>>> hw/rtl/easu_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// easu_csr
// Configuration registers: window length and timer rate, APB-style access.
// ----------------------------------------------------------------------------
module easu_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [easu_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [easu_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [easu_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output logic [easu_pkg::WIN_W-1:0]          window_ticks,
   output logic [easu_pkg::TPS_W-1:0]          ticks_per_second
);

   logic [easu_pkg::WIN_W-1:0] window_ff;
   logic [easu_pkg::WIN_W-1:0] window_in;
   logic [easu_pkg::TPS_W-1:0] tps_ff;
   logic [easu_pkg::TPS_W-1:0] tps_in;
   logic                       wr_en;
   easu_pkg::reg_sel_type      sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign sel        = easu_pkg::reg_sel_type'(csr_paddr[2]);

   always_comb begin
      window_in = window_ff;
      tps_in    = tps_ff;
      if (wr_en) begin
         unique case (sel)
            easu_pkg::REG_WINDOW: window_in = csr_pwdata[easu_pkg::WIN_W-1:0];
            easu_pkg::REG_TPS:    tps_in    = csr_pwdata[easu_pkg::TPS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         easu_pkg::REG_WINDOW: csr_prdata = {1'b0, window_ff};
         easu_pkg::REG_TPS:    csr_prdata = {2'b00, tps_ff};
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= easu_pkg::WINDOW_RESET;
         tps_ff    <= easu_pkg::TPS_RESET;
      end else begin
         window_ff <= window_in;
         tps_ff    <= tps_in;
      end
   end

   assign window_ticks     = window_ff;
   assign ticks_per_second = tps_ff;

endmodule

>>> hw/rtl/easu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// easu_ctrl
// Sequencer: capture; on update multiply, iterative divide, saturate; hand over result.
// ----------------------------------------------------------------------------
module easu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  easu_pkg::status_type   status,
   output easu_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_SAT,
      ST_FINISH
   } state_type;

   state_type                         state_ff;
   state_type                         state_in;
   logic [easu_pkg::DIV_CNT_W-1:0]    cnt_ff;
   logic [easu_pkg::DIV_CNT_W-1:0]    cnt_in;
   logic                              accept;
   logic                              cnt_last;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign cnt_last   = (cnt_ff == easu_pkg::DIV_CNT_W'(easu_pkg::DIV_CYCLES - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = status.update ? ST_MUL : ST_FINISH;
            end
         end
         ST_MUL: begin
            cmd.multiply = 1'b1;
            state_in     = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_last) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            cmd.saturate = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> hw/rtl/easu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// easu_datapath
// Reference state, window test, 32x32 multiply, radix-4 restoring divider,
// saturation and the result register.
// ----------------------------------------------------------------------------
module easu_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  easu_pkg::cmd_type                   cmd,
   output easu_pkg::status_type                status,
   input  logic                                req_tuser,
   input  logic [easu_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [easu_pkg::WIN_W-1:0]          window_ticks,
   input  logic [easu_pkg::TPS_W-1:0]          ticks_per_second,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [easu_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser
);

   localparam int TS  = easu_pkg::TS_W;
   localparam int CW  = easu_pkg::CNT_W;
   localparam int AW  = easu_pkg::ANGLE_W;
   localparam int SW  = easu_pkg::SPEED_W;
   localparam int NW  = easu_pkg::NUM_W;

   // architectural state
   logic [TS-1:0]        window_start_ff, window_start_in;
   logic [CW-1:0]        ref_count_ff,    ref_count_in;
   logic [TS-1:0]        ref_change_ff,   ref_change_in;
   logic [AW-1:0]        held_angle_ff,   held_angle_in;
   logic [SW-1:0]        held_speed_ff,   held_speed_in;
   logic                 rsp_valid_ff,    rsp_valid_in;

   // working registers
   logic                 updated_ff;
   logic                 neg_ff;
   logic [CW-1:0]        mag_ff;
   logic [TS-1:0]        dt_ff;
   logic [31:0]          tps3_ff;
   logic [NW-1:0]        num_ff;
   logic [NW-1:0]        quo_ff;
   logic [TS-1:0]        rem_ff;
   logic [AW-1:0]        rsp_angle_ff;
   logic [SW-1:0]        rsp_speed_ff;
   logic                 rsp_upd_ff;

   logic [TS-1:0]        now_ts;
   logic [CW-1:0]        cur;
   logic [TS-1:0]        change_ts;
   easu_pkg::func_type   func;
   logic [TS-1:0]        elapsed;
   logic [TS-1:0]        win_dbl;
   logic                 poll_due;
   logic [CW:0]          delta;
   logic [CW:0]          delta_neg;
   logic [CW-1:0]        mag;
   logic [AW-1:0]        angle3;
   logic [TS:0]          r1, r2, d33, s1, s2;
   logic                 ge1, ge2;
   logic [TS-1:0]        rem1, rem2;
   logic [NW-1:0]        q1, q2;
   logic                 q_over_pos, q_over_neg;
   logic [SW-1:0]        speed_sat;
   logic [SW-1:0]        q_neg;

   assign now_ts    = req_tdata[TS-1:0];
   assign cur       = req_tdata[TS+CW-1:TS];
   assign change_ts = req_tdata[2*TS+CW-1:TS+CW];
   assign func      = easu_pkg::func_type'(req_tuser);

   always_comb begin
      elapsed   = now_ts - window_start_ff;
      win_dbl   = {window_ticks, 1'b0};
      poll_due  = (func == easu_pkg::FUNC_POLL)
                  && (elapsed > {1'b0, window_ticks})
                  && ((cur != ref_count_ff) || (elapsed > win_dbl));
      delta     = {cur[CW-1], cur} - {ref_count_ff[CW-1], ref_count_ff};
      delta_neg = (CW+1)'(0) - delta;
      mag       = delta[CW] ? delta_neg[CW-1:0] : delta[CW-1:0];
      angle3    = {{(AW-CW){cur[CW-1]}}, cur}
                  + {{(AW-CW-1){cur[CW-1]}}, cur, 1'b0};
   end

   assign status.update    = poll_due;
   assign status.slot_free = ~rsp_valid_ff | rsp_tready;

   // two restoring divide steps per cycle
   always_comb begin
      d33  = {1'b0, dt_ff};
      r1   = {rem_ff, quo_ff[NW-1]};
      ge1  = (r1 >= d33);
      s1   = r1 - d33;
      rem1 = ge1 ? s1[TS-1:0] : r1[TS-1:0];
      q1   = {quo_ff[NW-2:0], ge1};
      r2   = {rem1, q1[NW-1]};
      ge2  = (r2 >= d33);
      s2   = r2 - d33;
      rem2 = ge2 ? s2[TS-1:0] : r2[TS-1:0];
      q2   = {q1[NW-2:0], ge2};
   end

   always_comb begin
      q_over_pos = (|quo_ff[NW-1:SW-1]);
      q_over_neg = (|quo_ff[NW-1:SW]) | (quo_ff[SW-1] & (|quo_ff[SW-2:0]));
      q_neg      = SW'(0) - quo_ff[SW-1:0];
      if (num_ff == '0) begin
         speed_sat = '0;
      end else if (dt_ff == '0) begin
         speed_sat = neg_ff ? easu_pkg::SPEED_MIN : easu_pkg::SPEED_MAX;
      end else if (neg_ff) begin
         speed_sat = q_over_neg ? easu_pkg::SPEED_MIN : q_neg;
      end else begin
         speed_sat = q_over_pos ? easu_pkg::SPEED_MAX : quo_ff[SW-1:0];
      end
   end

   always_comb begin
      window_start_in = window_start_ff;
      ref_count_in    = ref_count_ff;
      ref_change_in   = ref_change_ff;
      held_angle_in   = held_angle_ff;
      held_speed_in   = held_speed_ff;
      rsp_valid_in    = rsp_valid_ff;
      if (cmd.capture) begin
         if (func == easu_pkg::FUNC_RESTART) begin
            window_start_in = now_ts;
            ref_count_in    = cur;
            ref_change_in   = change_ts;
            held_angle_in   = '0;
            held_speed_in   = '0;
         end else if (poll_due) begin
            window_start_in = now_ts;
            ref_count_in    = cur;
            ref_change_in   = change_ts;
            held_angle_in   = angle3;
         end
      end
      if (cmd.saturate) begin
         held_speed_in = speed_sat;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_start_ff <= '0;
         ref_count_ff    <= '0;
         ref_change_ff   <= '0;
         held_angle_ff   <= '0;
         held_speed_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         window_start_ff <= window_start_in;
         ref_count_ff    <= ref_count_in;
         ref_change_ff   <= ref_change_in;
         held_angle_ff   <= held_angle_in;
         held_speed_ff   <= held_speed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         updated_ff <= poll_due;
         neg_ff     <= delta[CW];
         mag_ff     <= mag;
         dt_ff      <= change_ts - ref_change_ff;
         tps3_ff    <= {2'b00, ticks_per_second} + {1'b0, ticks_per_second, 1'b0};
      end
      if (cmd.multiply) begin
         num_ff <= NW'(mag_ff) * NW'(tps3_ff);
      end
      if (cmd.div_init) begin
         quo_ff <= num_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= q2;
         rem_ff <= rem2;
      end
      if (cmd.finish) begin
         rsp_angle_ff <= held_angle_ff;
         rsp_speed_ff <= held_speed_ff;
         rsp_upd_ff   <= updated_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(easu_pkg::RSP_DATA_W-AW-SW){1'b0}}, rsp_speed_ff, rsp_angle_ff};
   assign rsp_tuser  = rsp_upd_ff;

endmodule

>>> hw/rtl/encoder_angle_speed_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_angle_speed_update
// Quadrature encoder angle and period-based speed, refreshed at most once per window.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one poll or restart transaction (func in tuser; timestamp,
//  phase count and change time in tdata). rsp_* returns exactly one
//  transaction per request: held angle and speed, with tuser set when that
//  request refreshed them.
//  A restart or a poll that does not refresh goes from capture straight to
//  hand-over. A refreshing poll runs capture, 32x32 multiply, divider load,
//  the divider iterations at two quotient bits each, saturation, hand-over.
//  Requests are taken one at a time. The next one is accepted as soon as the
//  previous result sits in the output register, even while it is stalled. A
//  stalled receiver holds the result and blocks the next hand-over and with
//  it further requests. Reset clears the reference state and held values to
//  zero and loads the default window length and timer rate. Registers are
//  written via csr_* (window_ticks at 0x0, ticks_per_second at 0x4); the user
//  must do so only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module encoder_angle_speed_update (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] now_ts, [63:32] phase_count, [95:64] change_ts
   input  logic [easu_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] func
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [33:0] angle_tenths, [65:34] speed_tenths, [71:66] zero
   output logic [easu_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] updated
   output logic                                rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [easu_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [easu_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [easu_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [easu_pkg::WIN_W-1:0]  window_ticks;
   logic [easu_pkg::TPS_W-1:0]  ticks_per_second;
   easu_pkg::cmd_type           cmd;
   easu_pkg::status_type        status;

   easu_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .window_ticks     (window_ticks),
      .ticks_per_second (ticks_per_second)
   );

   easu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   easu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_tuser        (req_tuser),
      .req_tdata        (req_tdata),
      .window_ticks     (window_ticks),
      .ticks_per_second (ticks_per_second),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser)
   );

endmodule
